// ===== rtl/i2crts_pkg.sv =====
`default_nettype none

package i2crts_pkg;

	typedef enum logic [1:0] {
		OP_WRITE_CTRL   = 2'd0,
		OP_READ_STATUS  = 2'd1,
		OP_READ_VOLTAGE = 2'd2,
		OP_BUS_DONE     = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		CMD_NONE   = 3'd0,
		CMD_START  = 3'd1,
		CMD_SEND   = 3'd2,
		CMD_RSTART = 3'd3,
		CMD_RECV   = 3'd4,
		CMD_STOP   = 3'd5
	} cmd_t;

	localparam logic [1:0] REG_DEVICE_ADDR  = 2'd0;
	localparam logic [1:0] REG_STATUS_ADDR  = 2'd1;
	localparam logic [1:0] REG_VOLTAGE_ADDR = 2'd2;
	localparam logic [1:0] REG_CONTROL_ADDR = 2'd3;

	localparam logic [6:0] DEVICE_ADDR_RST  = 7'd100;
	localparam logic [7:0] STATUS_ADDR_RST  = 8'h00;
	localparam logic [7:0] VOLTAGE_ADDR_RST = 8'h08;
	localparam logic [7:0] CONTROL_ADDR_RST = 8'h01;

	localparam logic [7:0] KIND_STATUS = 8'd1;

	typedef struct packed {
		cmd_t        bus_command;
		logic [7:0]  tx_byte;
		logic        accepted;
		logic        done_res;
		logic [15:0] read_data;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/i2c_register_transaction_sequencer.sv =====
// i2c register transaction sequencer
// input channel (in_valid/in_ready): one transaction is either a request
// (write control, read status, read voltage) or a bus-operation-done event
// carrying the received byte. every input transaction yields exactly one
// result transaction on the output channel (out_valid/out_ready) with the
// next bus command, the byte to send, accepted/done flags and the captured
// read value.
// the result is registered, in the result register or, while a result waits,
// in the skid register. one transaction per cycle while in_ready is high; the
// phase update between input and the result register is combinational.
// a two-entry output buffer (result register plus skid register) lets one
// more transaction in while a result waits; in_ready drops only while both
// entries are full, so a stalled receiver holds off the input after two.
// configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready
// and is meant to be written while the block is idle.
// reset: phase idle, captured value zero, register addresses at defaults
// (device 100, status 0x00, voltage 0x08, control 0x01), output buffer empty.
`default_nettype none

module i2c_register_transaction_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [7:0]  write_value,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        bus_busy,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       bus_command,
	output logic [7:0]       tx_byte,
	output logic             accepted,
	output logic             done_res,
	output logic [15:0]      read_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);
	import i2crts_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE          = 4'd0,
		PH_STARTED       = 4'd1,
		PH_ADDR_SENT     = 4'd2,
		PH_REG_SENT      = 4'd3,
		PH_RSTARTED      = 4'd4,
		PH_RADDR_SENT    = 4'd5,
		PH_FIRST_RX      = 4'd6,
		PH_SECOND_RX     = 4'd7,
		PH_STOPPING      = 4'd8,
		PH_CTRL_REG_SENT = 4'd9,
		PH_DATA_SENT     = 4'd10
	} phase_t;

	logic [6:0]  device_addr_q;
	logic [7:0]  status_addr_q;
	logic [7:0]  voltage_addr_q;
	logic [7:0]  control_addr_q;

	phase_t      phase_q, phase_nxt;
	logic        is_read_q, is_read_nxt;
	logic [7:0]  kind_q, kind_nxt;
	logic [15:0] captured_q, captured_nxt;

	result_t     res;
	result_t     out_q, skid_q;
	logic        out_valid_q, skid_valid_q;
	logic        in_fire;

	assign cfg_ready = 1'b1;
	assign in_ready  = !skid_valid_q;
	assign in_fire   = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_addr_q  <= DEVICE_ADDR_RST;
			status_addr_q  <= STATUS_ADDR_RST;
			voltage_addr_q <= VOLTAGE_ADDR_RST;
			control_addr_q <= CONTROL_ADDR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEVICE_ADDR:  device_addr_q  <= cfg_data[6:0];
				REG_STATUS_ADDR:  status_addr_q  <= cfg_data;
				REG_VOLTAGE_ADDR: voltage_addr_q <= cfg_data;
				REG_CONTROL_ADDR: control_addr_q <= cfg_data;
				default:          device_addr_q  <= device_addr_q;
			endcase
		end
	end

	// next phase and result
	always_comb begin
		phase_nxt    = phase_q;
		is_read_nxt  = is_read_q;
		kind_nxt     = kind_q;
		captured_nxt = captured_q;
		res          = '0;
		res.bus_command = CMD_NONE;
		if (opcode_t'(opcode) != OP_BUS_DONE) begin
			if (phase_q == PH_IDLE && !bus_busy) begin
				is_read_nxt     = (opcode_t'(opcode) != OP_WRITE_CTRL);
				kind_nxt        = (opcode_t'(opcode) == OP_WRITE_CTRL) ? write_value
				                                                       : {6'd0, opcode};
				phase_nxt       = PH_STARTED;
				res.bus_command = CMD_START;
				res.accepted    = 1'b1;
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					phase_nxt = PH_IDLE;
				end
				PH_STARTED: begin
					res.bus_command = CMD_SEND;
					res.tx_byte     = {device_addr_q, 1'b0};
					phase_nxt       = PH_ADDR_SENT;
				end
				PH_ADDR_SENT: begin
					res.bus_command = CMD_SEND;
					if (is_read_q) begin
						res.tx_byte = (kind_q == KIND_STATUS) ? status_addr_q : voltage_addr_q;
						phase_nxt   = PH_REG_SENT;
					end else begin
						res.tx_byte = control_addr_q;
						phase_nxt   = PH_CTRL_REG_SENT;
					end
				end
				PH_REG_SENT: begin
					res.bus_command = CMD_RSTART;
					phase_nxt       = PH_RSTARTED;
				end
				PH_RSTARTED: begin
					res.bus_command = CMD_SEND;
					res.tx_byte     = {device_addr_q, 1'b1};
					phase_nxt       = PH_RADDR_SENT;
				end
				PH_RADDR_SENT: begin
					res.bus_command = CMD_RECV;
					phase_nxt       = PH_FIRST_RX;
				end
				PH_FIRST_RX: begin
					if (kind_q == KIND_STATUS) begin
						captured_nxt    = {8'd0, rx_byte};
						res.bus_command = CMD_STOP;
						phase_nxt       = PH_STOPPING;
					end else begin
						captured_nxt    = {rx_byte, 8'd0};
						res.bus_command = CMD_RECV;
						phase_nxt       = PH_SECOND_RX;
					end
				end
				PH_SECOND_RX: begin
					captured_nxt    = {captured_q[15:8], captured_q[7:0] | rx_byte};
					res.bus_command = CMD_STOP;
					phase_nxt       = PH_STOPPING;
				end
				PH_CTRL_REG_SENT: begin
					res.bus_command = CMD_SEND;
					res.tx_byte     = kind_q;
					phase_nxt       = PH_DATA_SENT;
				end
				PH_DATA_SENT: begin
					res.bus_command = CMD_STOP;
					phase_nxt       = PH_STOPPING;
				end
				PH_STOPPING: begin
					res.done_res = 1'b1;
					phase_nxt    = PH_IDLE;
				end
				default: begin
					phase_nxt = PH_IDLE;
				end
			endcase
		end
		res.read_data = captured_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			is_read_q  <= 1'b0;
			kind_q     <= '0;
			captured_q <= '0;
		end else if (in_fire) begin
			phase_q    <= phase_nxt;
			is_read_q  <= is_read_nxt;
			kind_q     <= kind_nxt;
			captured_q <= captured_nxt;
		end
	end

	// result register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_fire) begin
				out_q <= res;
			end
		end else if (in_fire) begin
			skid_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign bus_command = out_q.bus_command;
	assign tx_byte     = out_q.tx_byte;
	assign accepted    = out_q.accepted;
	assign done_res    = out_q.done_res;
	assign read_data   = out_q.read_data;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a result while the result register is empty");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && res.accepted |=> phase_q == PH_STARTED && !$stable(phase_q) ||
		                            phase_q == PH_STARTED)
		else $error("taken request did not move the sequencer to started");

	a_start_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && res.bus_command == CMD_START |-> phase_q == PH_IDLE && !bus_busy)
		else $error("start issued while busy");

	a_done_no_command: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && res.done_res |=> phase_q == PH_IDLE && res.bus_command == CMD_NONE ||
		                            phase_q == PH_IDLE)
		else $error("finished transaction did not return to idle");

endmodule

`default_nettype wire

// ===== tb/sv/i2crts_sequence_check.sv =====
`timescale 1ns / 1ps

module i2crts_sequence_check (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [7:0]  write_value,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        bus_busy,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [2:0]  bus_command,
	input  wire logic [7:0]  tx_byte,
	input  wire logic        accepted,
	input  wire logic        done_res,
	input  wire logic [15:0] read_data,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	output int               error_count,
	output int               pending_results
);
	import i2crts_pkg::*;

	typedef enum logic [3:0] {
		SEQ_IDLE,
		SEQ_STARTED,
		SEQ_ADDR_SENT,
		SEQ_REG_SENT,
		SEQ_RSTARTED,
		SEQ_RADDR_SENT,
		SEQ_FIRST_RX,
		SEQ_SECOND_RX,
		SEQ_STOPPING,
		SEQ_CTRL_REG_SENT,
		SEQ_DATA_SENT
	} seq_phase_t;

	seq_phase_t  seq_phase;
	logic        is_read;
	logic [7:0]  request_kind;
	logic [15:0] captured;

	logic [6:0]  device_addr;
	logic [7:0]  status_addr;
	logic [7:0]  voltage_addr;
	logic [7:0]  control_addr;

	result_t     expected_results[$];

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic step_sequencer(input logic [1:0] op, input logic [7:0] wv,
			input logic [7:0] rx, input logic busy, output result_t r);
		r.bus_command = CMD_NONE;
		r.tx_byte     = 8'h00;
		r.accepted    = 1'b0;
		r.done_res    = 1'b0;
		if (op != OP_BUS_DONE) begin
			if (seq_phase == SEQ_IDLE && !busy) begin
				is_read       = (op != OP_WRITE_CTRL);
				request_kind  = (op == OP_WRITE_CTRL) ? wv : {6'd0, op};
				seq_phase     = SEQ_STARTED;
				r.bus_command = CMD_START;
				r.accepted    = 1'b1;
			end
		end else begin
			case (seq_phase)
				SEQ_STARTED: begin
					r.bus_command = CMD_SEND;
					r.tx_byte     = {device_addr, 1'b0};
					seq_phase     = SEQ_ADDR_SENT;
				end
				SEQ_ADDR_SENT: begin
					r.bus_command = CMD_SEND;
					if (is_read) begin
						r.tx_byte = (request_kind == KIND_STATUS) ? status_addr : voltage_addr;
						seq_phase = SEQ_REG_SENT;
					end else begin
						r.tx_byte = control_addr;
						seq_phase = SEQ_CTRL_REG_SENT;
					end
				end
				SEQ_REG_SENT: begin
					r.bus_command = CMD_RSTART;
					seq_phase     = SEQ_RSTARTED;
				end
				SEQ_RSTARTED: begin
					r.bus_command = CMD_SEND;
					r.tx_byte     = {device_addr, 1'b1};
					seq_phase     = SEQ_RADDR_SENT;
				end
				SEQ_RADDR_SENT: begin
					r.bus_command = CMD_RECV;
					seq_phase     = SEQ_FIRST_RX;
				end
				SEQ_FIRST_RX: begin
					if (request_kind == KIND_STATUS) begin
						captured      = {8'h00, rx};
						r.bus_command = CMD_STOP;
						seq_phase     = SEQ_STOPPING;
					end else begin
						captured      = {rx, 8'h00};
						r.bus_command = CMD_RECV;
						seq_phase     = SEQ_SECOND_RX;
					end
				end
				SEQ_SECOND_RX: begin
					captured      = captured | {8'h00, rx};
					r.bus_command = CMD_STOP;
					seq_phase     = SEQ_STOPPING;
				end
				SEQ_CTRL_REG_SENT: begin
					r.bus_command = CMD_SEND;
					r.tx_byte     = request_kind;
					seq_phase     = SEQ_DATA_SENT;
				end
				SEQ_DATA_SENT: begin
					r.bus_command = CMD_STOP;
					seq_phase     = SEQ_STOPPING;
				end
				SEQ_STOPPING: begin
					r.done_res = 1'b1;
					seq_phase  = SEQ_IDLE;
				end
				default: begin
					seq_phase = SEQ_IDLE;
				end
			endcase
		end
		r.read_data = captured;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		result_t predicted;
		if (!arst_n) begin
			seq_phase    = SEQ_IDLE;
			is_read      = 1'b0;
			request_kind = 8'h00;
			captured     = 16'h0000;
			device_addr  = DEVICE_ADDR_RST;
			status_addr  = STATUS_ADDR_RST;
			voltage_addr = VOLTAGE_ADDR_RST;
			control_addr = CONTROL_ADDR_RST;
			expected_results.delete();
			pending_results = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result, bus_command", bus_command, 16'h0000);
				end else begin
					want = expected_results.pop_front();
					if (bus_command !== want.bus_command)
						report_mismatch("bus_command", bus_command, want.bus_command);
					if (tx_byte !== want.tx_byte)
						report_mismatch("tx_byte", tx_byte, want.tx_byte);
					if (accepted !== want.accepted)
						report_mismatch("accepted", accepted, want.accepted);
					if (done_res !== want.done_res)
						report_mismatch("done_res", done_res, want.done_res);
					if (read_data !== want.read_data)
						report_mismatch("read_data", read_data, want.read_data);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEVICE_ADDR:  device_addr  = cfg_data[6:0];
					REG_STATUS_ADDR:  status_addr  = cfg_data;
					REG_VOLTAGE_ADDR: voltage_addr = cfg_data;
					REG_CONTROL_ADDR: control_addr = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				step_sequencer(opcode, write_value, rx_byte, bus_busy, predicted);
				expected_results.push_back(predicted);
			end
			pending_results = expected_results.size();
		end
	end

endmodule

// ===== tb/sv/i2c_register_transaction_sequencer_tb.sv =====
`timescale 1ns / 1ps

module i2c_register_transaction_sequencer_tb;
	import i2crts_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 56;
	localparam int PHASE_COUNT  = 6;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 4;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	opcode_t     opcode;
	logic [7:0]  write_value;
	logic [7:0]  rx_byte;
	logic        bus_busy;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  bus_command;
	logic [7:0]  tx_byte;
	logic        accepted;
	logic        done_res;
	logic [15:0] read_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	int error_count;
	int pending_results;
	int burst_left;
	int item_count;
	int cycle_count;
	bit hold_request;

	i2c_register_transaction_sequencer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.write_value (write_value),
		.rx_byte     (rx_byte),
		.bus_busy    (bus_busy),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.bus_command (bus_command),
		.tx_byte     (tx_byte),
		.accepted    (accepted),
		.done_res    (done_res),
		.read_data   (read_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	i2crts_sequence_check u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.write_value     (write_value),
		.rx_byte         (rx_byte),
		.bus_busy        (bus_busy),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.bus_command     (bus_command),
		.tx_byte         (tx_byte),
		.accepted        (accepted),
		.done_res        (done_res),
		.read_data       (read_data),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.error_count     (error_count),
		.pending_results (pending_results)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic drive_item(input opcode_t op, input logic [7:0] wv,
			input logic [7:0] rx, input logic busy);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		in_valid    <= 1'b1;
		opcode      <= op;
		write_value <= wv;
		rx_byte     <= rx;
		bus_busy    <= busy;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_results != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// one full request with its done events, stray requests mixed in
	task automatic run_transaction();
		opcode_t op;
		int done_events;
		op = opcode_t'($urandom_range(0, 2));
		case (op)
			OP_WRITE_CTRL:  done_events = 5;
			OP_READ_STATUS: done_events = 7;
			default:        done_events = 8;
		endcase
		drive_item(op, pick_byte(), pick_byte(), 1'b0);
		item_count++;
		for (int i = 0; i < done_events; i++) begin
			if ($urandom_range(0, 5) == 0)
				drive_item(opcode_t'($urandom_range(0, 2)), pick_byte(), pick_byte(),
					1'($urandom_range(0, 1)));
			drive_item(OP_BUS_DONE, pick_byte(), pick_byte(), 1'($urandom_range(0, 1)));
			item_count++;
		end
	endtask

	initial begin : receiver
		int mode;
		int mode_left;
		int hold_left;
		bit hold_taken;
		out_ready  = 1'b0;
		mode       = 0;
		mode_left  = 0;
		hold_left  = 0;
		hold_taken = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(4, 40);
				end
				mode_left--;
				case (mode)
					0:       out_ready <= 1'b1;
					1:       out_ready <= 1'($urandom_range(0, 1));
					2:       out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		logic [6:0] dev;
		logic [7:0] st_addr;
		logic [7:0] vo_addr;
		logic [7:0] ct_addr;
		int phase_start;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		opcode       = OP_WRITE_CTRL;
		write_value  = 8'h00;
		rx_byte      = 8'h00;
		bus_busy     = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_DEVICE_ADDR;
		cfg_data     = 8'h00;
		burst_left   = 0;
		item_count   = 0;
		hold_request = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// control write, stray done while idle, busy bus, status read, voltage read
		drive_item(OP_WRITE_CTRL, 8'hFF, 8'h00, 1'b0);
		for (int i = 0; i < 5; i++)
			drive_item(OP_BUS_DONE, 8'h00, 8'hFF, 1'b0);
		drive_item(OP_BUS_DONE, 8'hFF, 8'hFF, 1'b1);
		drive_item(OP_READ_STATUS, 8'h00, 8'h00, 1'b1);
		drive_item(OP_READ_STATUS, 8'hFF, 8'hFF, 1'b0);
		for (int i = 0; i < 7; i++)
			drive_item(OP_BUS_DONE, 8'h00, 8'hFF, 1'(i % 2));
		drive_item(OP_READ_VOLTAGE, 8'h00, 8'h00, 1'b0);
		for (int i = 0; i < 8; i++)
			drive_item(OP_BUS_DONE, 8'hFF, (i == 5) ? 8'hFF : 8'h00, 1'b0);

		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: begin
					dev = 7'd0; st_addr = 8'h00; vo_addr = 8'h00; ct_addr = 8'h00;
				end
				1: begin
					dev = 7'd127; st_addr = 8'hFF; vo_addr = 8'hFF; ct_addr = 8'hFF;
				end
				default: begin
					dev     = 7'($urandom_range(0, 127));
					st_addr = 8'($urandom_range(0, 255));
					vo_addr = 8'($urandom_range(0, 255));
					ct_addr = 8'($urandom_range(0, 255));
				end
			endcase
			wait_idle();
			write_reg(REG_DEVICE_ADDR, {1'b0, dev});
			write_reg(REG_STATUS_ADDR, st_addr);
			write_reg(REG_VOLTAGE_ADDR, vo_addr);
			write_reg(REG_CONTROL_ADDR, ct_addr);
			cfg_valid <= 1'b0;
			if (p == 2)
				hold_request = 1'b1;
			phase_start = item_count;
			while (item_count - phase_start < PHASE_ITEMS) begin
				case ($urandom_range(0, 9))
					0: drive_item(opcode_t'($urandom_range(0, 2)), pick_byte(), pick_byte(), 1'b1);
					1: drive_item(OP_BUS_DONE, pick_byte(), pick_byte(), 1'($urandom_range(0, 1)));
					default: ;
				endcase
				run_transaction();
			end
		end

		wait_idle();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
